// ===== src/triangle_circumcenter_unit_macros.svh =====
// Assertion macros shared by the triangle circumcenter checker
`ifndef TRIANGLE_CIRCUMCENTER_UNIT_MACROS_SVH
`define TRIANGLE_CIRCUMCENTER_UNIT_MACROS_SVH

// same-cycle implication
`define TCU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcu: same-cycle implication violated");

// next-cycle implication
`define TCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcu: next-cycle implication violated");

`endif

// ===== src/tcu_pkg.sv =====
// Shared constants for the triangle circumcenter unit
package tcu_pkg;

    localparam int OUT_BITS = 32;

    localparam logic [OUT_BITS-1:0] SAT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] SAT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

endpackage

// ===== src/triangle_circumcenter_unit.sv =====
// Triangle circumcenter unit: pipelined Cramer solve with a bit-per-stage divider
//
// Takes two points p1 and p2 in signed Q8.8 and returns the circumcenter of the
// triangle (origin, p1, p2) in signed Q24.8, truncated toward zero and clipped
// to 32 bits (saturated flags the clip). Collinear points give zero outputs with
// degenerate set. The unit accepts one beat per clock with no gaps while
// point_stall is low. Each result passes through six stages of squares,
// products and numerators, one range-check stage, 32 restoring-divider stages
// (one quotient bit each), one sign/clip stage and the output register. A skid
// register behind the output takes one more beat while a result waits;
// point_stall then rises until the output drains.
module triangle_circumcenter_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  logic signed [COORD_BITS-1:0]        p1_x,
    input  logic signed [COORD_BITS-1:0]        p1_y,
    input  logic signed [COORD_BITS-1:0]        p2_x,
    input  logic signed [COORD_BITS-1:0]        p2_y,
    output logic                                center_valid,
    input  logic                                center_stall,
    output logic signed [tcu_pkg::OUT_BITS-1:0] center_x,
    output logic signed [tcu_pkg::OUT_BITS-1:0] center_y,
    output logic                                degenerate,
    output logic                                saturated
);
    import tcu_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C;
    localparam int DET_W = 2 * C + 1;
    localparam int PP_W  = 2 * C + 1;
    localparam int PW    = 3 * C + 1;
    localparam int MW    = 3 * C;
    localparam int DW    = 2 * C + 1;
    localparam int QB    = OUT_BITS;
    localparam int CW    = MW + QB + 1;

    typedef struct packed {
        logic degen;
        logic neg_x;
        logic neg_y;
        logic big_x;
        logic big_y;
    } flags_t;

    typedef struct packed {
        logic [QB-1:0] x;
        logic [QB-1:0] y;
        logic          deg;
        logic          sat;
    } res_t;

    logic en;

    logic [5:0] st_valid_reg;

    // stage 1
    logic signed [C-1:0]    s1_x1_reg, s1_y1_reg, s1_x2_reg, s1_y2_reg;
    logic signed [SQ_W-1:0] s1_xx1_reg, s1_yy1_reg, s1_xx2_reg, s1_yy2_reg;
    logic signed [SQ_W-1:0] s1_x1y2_reg, s1_x2y1_reg;
    logic signed [SQ_W-1:0] s1_xx1_next, s1_yy1_next, s1_xx2_next, s1_yy2_next;
    logic signed [SQ_W-1:0] s1_x1y2_next, s1_x2y1_next;

    // stage 2
    logic signed [C-1:0]     s2_x1_reg, s2_y1_reg, s2_x2_reg, s2_y2_reg;
    logic [SQ_W-1:0]         s2_sq1_reg, s2_sq2_reg, s2_sq1_next, s2_sq2_next;
    logic signed [DET_W-1:0] s2_det_reg, s2_det_next;
    logic signed [DET_W-1:0] sum1, sum2;

    // stage 3
    logic signed [PP_W-1:0]  s3_y2s1_lo_reg, s3_y2s1_hi_reg, s3_y1s2_lo_reg, s3_y1s2_hi_reg;
    logic signed [PP_W-1:0]  s3_x1s2_lo_reg, s3_x1s2_hi_reg, s3_x2s1_lo_reg, s3_x2s1_hi_reg;
    logic signed [PP_W-1:0]  s3_y2s1_lo_next, s3_y2s1_hi_next, s3_y1s2_lo_next;
    logic signed [PP_W-1:0]  s3_y1s2_hi_next, s3_x1s2_lo_next, s3_x1s2_hi_next;
    logic signed [PP_W-1:0]  s3_x2s1_lo_next, s3_x2s1_hi_next;
    logic signed [DET_W-1:0] s3_det_reg;

    // stage 4
    logic signed [PW-1:0]    s4_y2s1_reg, s4_y1s2_reg, s4_x1s2_reg, s4_x2s1_reg;
    logic signed [PW-1:0]    s4_y2s1_next, s4_y1s2_next, s4_x1s2_next, s4_x2s1_next;
    logic signed [DET_W-1:0] s4_det_reg;

    // stage 5
    logic signed [PW-1:0] s5_nx_reg, s5_ny_reg, s5_nx_next, s5_ny_next;
    logic [DW-1:0]        s5_d_reg, s5_d_next;
    logic                 s5_dneg_reg, s5_degen_reg, s5_degen_next;
    logic [DET_W-1:0]     det_mag;

    // stage 6
    logic [MW-1:0] s6_mx_reg, s6_my_reg, s6_mx_next, s6_my_next;
    logic [DW-1:0] s6_d_reg;
    flags_t        s6_flags_reg, s6_flags_next;
    logic [PW-1:0] abs_x, abs_y;

    // range check and divider
    logic [MW+QB-1:0] ext_x, ext_y;
    logic [MW-1:0]    hi_x, hi_y;
    flags_t           dv_flags0_next;

    logic [QB:0]    dv_valid_reg;
    logic [DW-1:0]  dv_rem_x_reg [QB+1];
    logic [DW-1:0]  dv_rem_y_reg [QB+1];
    logic [DW-1:0]  dv_rem_x_next [QB+1];
    logic [DW-1:0]  dv_rem_y_next [QB+1];
    logic [QB-1:0]  dv_lq_x_reg [QB+1];
    logic [QB-1:0]  dv_lq_y_reg [QB+1];
    logic [QB-1:0]  dv_lq_x_next [QB+1];
    logic [QB-1:0]  dv_lq_y_next [QB+1];
    logic [DW-1:0]  dv_d_reg [QB+1];
    flags_t         dv_flags_reg [QB+1];
    logic [DW:0]    dv_tx [QB];
    logic [DW:0]    dv_ty [QB];

    // result, output and skid
    logic          res_valid_reg;
    res_t          res_reg, res_next;
    logic [QB-1:0] q_x, q_y;
    logic          sat_x, sat_y;
    flags_t        fin;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg, skid_reg;
    logic take, push;

    assign en          = !skid_valid_reg;
    assign point_stall = skid_valid_reg;

    always_comb
    begin
        s1_xx1_next  = SQ_W'(p1_x) * SQ_W'(p1_x);
        s1_yy1_next  = SQ_W'(p1_y) * SQ_W'(p1_y);
        s1_xx2_next  = SQ_W'(p2_x) * SQ_W'(p2_x);
        s1_yy2_next  = SQ_W'(p2_y) * SQ_W'(p2_y);
        s1_x1y2_next = SQ_W'(p1_x) * SQ_W'(p2_y);
        s1_x2y1_next = SQ_W'(p2_x) * SQ_W'(p1_y);
    end

    always_comb
    begin
        sum1        = DET_W'(s1_xx1_reg) + DET_W'(s1_yy1_reg);
        sum2        = DET_W'(s1_xx2_reg) + DET_W'(s1_yy2_reg);
        s2_sq1_next = sum1[SQ_W-1:0];
        s2_sq2_next = sum2[SQ_W-1:0];
        s2_det_next = DET_W'(s1_x1y2_reg) - DET_W'(s1_x2y1_reg);
    end

    always_comb
    begin
        s3_y2s1_lo_next = PP_W'(s2_y2_reg) * PP_W'($signed({1'b0, s2_sq1_reg[C-1:0]}));
        s3_y2s1_hi_next = PP_W'(s2_y2_reg) * PP_W'($signed({1'b0, s2_sq1_reg[SQ_W-1:C]}));
        s3_y1s2_lo_next = PP_W'(s2_y1_reg) * PP_W'($signed({1'b0, s2_sq2_reg[C-1:0]}));
        s3_y1s2_hi_next = PP_W'(s2_y1_reg) * PP_W'($signed({1'b0, s2_sq2_reg[SQ_W-1:C]}));
        s3_x1s2_lo_next = PP_W'(s2_x1_reg) * PP_W'($signed({1'b0, s2_sq2_reg[C-1:0]}));
        s3_x1s2_hi_next = PP_W'(s2_x1_reg) * PP_W'($signed({1'b0, s2_sq2_reg[SQ_W-1:C]}));
        s3_x2s1_lo_next = PP_W'(s2_x2_reg) * PP_W'($signed({1'b0, s2_sq1_reg[C-1:0]}));
        s3_x2s1_hi_next = PP_W'(s2_x2_reg) * PP_W'($signed({1'b0, s2_sq1_reg[SQ_W-1:C]}));
    end

    always_comb
    begin
        s4_y2s1_next = (PW'(s3_y2s1_hi_reg) <<< C) + PW'(s3_y2s1_lo_reg);
        s4_y1s2_next = (PW'(s3_y1s2_hi_reg) <<< C) + PW'(s3_y1s2_lo_reg);
        s4_x1s2_next = (PW'(s3_x1s2_hi_reg) <<< C) + PW'(s3_x1s2_lo_reg);
        s4_x2s1_next = (PW'(s3_x2s1_hi_reg) <<< C) + PW'(s3_x2s1_lo_reg);
    end

    always_comb
    begin
        s5_nx_next    = s4_y2s1_reg - s4_y1s2_reg;
        s5_ny_next    = s4_x1s2_reg - s4_x2s1_reg;
        det_mag       = s4_det_reg[DET_W-1] ? DET_W'(-s4_det_reg) : DET_W'(s4_det_reg);
        s5_d_next     = {det_mag[DW-2:0], 1'b0};
        s5_degen_next = (s4_det_reg == '0);
    end

    always_comb
    begin
        abs_x               = s5_nx_reg[PW-1] ? PW'(-s5_nx_reg) : PW'(s5_nx_reg);
        abs_y               = s5_ny_reg[PW-1] ? PW'(-s5_ny_reg) : PW'(s5_ny_reg);
        s6_mx_next          = abs_x[MW-1:0];
        s6_my_next          = abs_y[MW-1:0];
        s6_flags_next.degen = s5_degen_reg;
        s6_flags_next.neg_x = s5_nx_reg[PW-1] ^ s5_dneg_reg;
        s6_flags_next.neg_y = s5_ny_reg[PW-1] ^ s5_dneg_reg;
        s6_flags_next.big_x = 1'b0;
        s6_flags_next.big_y = 1'b0;
    end

    // split the magnitude at the 32-bit quotient boundary; flag quotients that cannot fit
    always_comb
    begin
        ext_x                = {QB'(0), s6_mx_reg};
        ext_y                = {QB'(0), s6_my_reg};
        hi_x                 = ext_x[MW+QB-1:QB];
        hi_y                 = ext_y[MW+QB-1:QB];
        dv_flags0_next       = s6_flags_reg;
        dv_flags0_next.big_x = CW'(s6_mx_reg) >= CW'({s6_d_reg, QB'(0)});
        dv_flags0_next.big_y = CW'(s6_my_reg) >= CW'({s6_d_reg, QB'(0)});
    end

    always_comb
    begin
        dv_rem_x_next[0] = hi_x[DW-1:0];
        dv_rem_y_next[0] = hi_y[DW-1:0];
        dv_lq_x_next[0]  = ext_x[QB-1:0];
        dv_lq_y_next[0]  = ext_y[QB-1:0];
        for (int k = 0; k < QB; k++)
        begin
            dv_tx[k] = {dv_rem_x_reg[k], dv_lq_x_reg[k][QB-1]};
            dv_ty[k] = {dv_rem_y_reg[k], dv_lq_y_reg[k][QB-1]};
            if (dv_tx[k] >= {1'b0, dv_d_reg[k]})
            begin
                dv_rem_x_next[k+1] = DW'(dv_tx[k] - {1'b0, dv_d_reg[k]});
                dv_lq_x_next[k+1]  = {dv_lq_x_reg[k][QB-2:0], 1'b1};
            end
            else
            begin
                dv_rem_x_next[k+1] = dv_tx[k][DW-1:0];
                dv_lq_x_next[k+1]  = {dv_lq_x_reg[k][QB-2:0], 1'b0};
            end
            if (dv_ty[k] >= {1'b0, dv_d_reg[k]})
            begin
                dv_rem_y_next[k+1] = DW'(dv_ty[k] - {1'b0, dv_d_reg[k]});
                dv_lq_y_next[k+1]  = {dv_lq_y_reg[k][QB-2:0], 1'b1};
            end
            else
            begin
                dv_rem_y_next[k+1] = dv_ty[k][DW-1:0];
                dv_lq_y_next[k+1]  = {dv_lq_y_reg[k][QB-2:0], 1'b0};
            end
        end
    end

    // apply sign, clip to 32 bits, zero out collinear cases
    always_comb
    begin
        fin   = dv_flags_reg[QB];
        q_x   = dv_lq_x_reg[QB];
        q_y   = dv_lq_y_reg[QB];
        sat_x = fin.big_x || (fin.neg_x ? (q_x > SAT_MIN) : (q_x > SAT_MAX));
        sat_y = fin.big_y || (fin.neg_y ? (q_y > SAT_MIN) : (q_y > SAT_MAX));
        if (fin.degen)
        begin
            res_next.x   = '0;
            res_next.y   = '0;
            res_next.deg = 1'b1;
            res_next.sat = 1'b0;
        end
        else
        begin
            if (sat_x)
                res_next.x = fin.neg_x ? SAT_MIN : SAT_MAX;
            else
                res_next.x = fin.neg_x ? (~q_x + QB'(1)) : q_x;
            if (sat_y)
                res_next.y = fin.neg_y ? SAT_MIN : SAT_MAX;
            else
                res_next.y = fin.neg_y ? (~q_y + QB'(1)) : q_y;
            res_next.deg = 1'b0;
            res_next.sat = sat_x || sat_y;
        end
    end

    always_comb
    begin
        take = !out_valid_reg || !center_stall;
        push = en && res_valid_reg;
        if (take)
        begin
            out_valid_next  = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = skid_valid_reg || push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg   <= '0;
            dv_valid_reg   <= '0;
            res_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                st_valid_reg  <= {st_valid_reg[4:0], point_valid};
                dv_valid_reg  <= {dv_valid_reg[QB-1:0], st_valid_reg[5]};
                res_valid_reg <= dv_valid_reg[QB];
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x1_reg      <= p1_x;
            s1_y1_reg      <= p1_y;
            s1_x2_reg      <= p2_x;
            s1_y2_reg      <= p2_y;
            s1_xx1_reg     <= s1_xx1_next;
            s1_yy1_reg     <= s1_yy1_next;
            s1_xx2_reg     <= s1_xx2_next;
            s1_yy2_reg     <= s1_yy2_next;
            s1_x1y2_reg    <= s1_x1y2_next;
            s1_x2y1_reg    <= s1_x2y1_next;

            s2_x1_reg      <= s1_x1_reg;
            s2_y1_reg      <= s1_y1_reg;
            s2_x2_reg      <= s1_x2_reg;
            s2_y2_reg      <= s1_y2_reg;
            s2_sq1_reg     <= s2_sq1_next;
            s2_sq2_reg     <= s2_sq2_next;
            s2_det_reg     <= s2_det_next;

            s3_y2s1_lo_reg <= s3_y2s1_lo_next;
            s3_y2s1_hi_reg <= s3_y2s1_hi_next;
            s3_y1s2_lo_reg <= s3_y1s2_lo_next;
            s3_y1s2_hi_reg <= s3_y1s2_hi_next;
            s3_x1s2_lo_reg <= s3_x1s2_lo_next;
            s3_x1s2_hi_reg <= s3_x1s2_hi_next;
            s3_x2s1_lo_reg <= s3_x2s1_lo_next;
            s3_x2s1_hi_reg <= s3_x2s1_hi_next;
            s3_det_reg     <= s2_det_reg;

            s4_y2s1_reg    <= s4_y2s1_next;
            s4_y1s2_reg    <= s4_y1s2_next;
            s4_x1s2_reg    <= s4_x1s2_next;
            s4_x2s1_reg    <= s4_x2s1_next;
            s4_det_reg     <= s3_det_reg;

            s5_nx_reg      <= s5_nx_next;
            s5_ny_reg      <= s5_ny_next;
            s5_d_reg       <= s5_d_next;
            s5_dneg_reg    <= s4_det_reg[DET_W-1];
            s5_degen_reg   <= s5_degen_next;

            s6_mx_reg      <= s6_mx_next;
            s6_my_reg      <= s6_my_next;
            s6_d_reg       <= s5_d_reg;
            s6_flags_reg   <= s6_flags_next;

            for (int k = 0; k <= QB; k++)
            begin
                dv_rem_x_reg[k] <= dv_rem_x_next[k];
                dv_rem_y_reg[k] <= dv_rem_y_next[k];
                dv_lq_x_reg[k]  <= dv_lq_x_next[k];
                dv_lq_y_reg[k]  <= dv_lq_y_next[k];
            end
            dv_d_reg[0]     <= s6_d_reg;
            dv_flags_reg[0] <= dv_flags0_next;
            for (int k = 1; k <= QB; k++)
            begin
                dv_d_reg[k]     <= dv_d_reg[k-1];
                dv_flags_reg[k] <= dv_flags_reg[k-1];
            end

            res_reg <= res_next;
        end

        if (take)
            out_reg <= skid_valid_reg ? skid_reg : res_reg;
        else if (push)
            skid_reg <= res_reg;
    end

    assign center_valid = out_valid_reg;
    assign center_x     = out_reg.x;
    assign center_y     = out_reg.y;
    assign degenerate   = out_reg.deg;
    assign saturated    = out_reg.sat;

endmodule

// ===== src/tcu_checker.sv =====
// Port-level checker for the triangle circumcenter unit, with its bind
`include "triangle_circumcenter_unit_macros.svh"

module tcu_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                point_stall,
    input logic                                center_valid,
    input logic                                center_stall,
    input logic signed [tcu_pkg::OUT_BITS-1:0] center_x,
    input logic signed [tcu_pkg::OUT_BITS-1:0] center_y,
    input logic                                degenerate,
    input logic                                saturated
);
    import tcu_pkg::*;

    // collinear beats carry zeros and no clip
    `TCU_ASSERT_IMPLY(a_degen_zero, clk, rst_n, center_valid && degenerate, center_x == '0 && center_y == '0 && !saturated)

    // a clip leaves at least one coordinate at a rail
    `TCU_ASSERT_IMPLY(a_sat_rail, clk, rst_n, center_valid && saturated, center_x == SAT_MAX || center_x == SAT_MIN || center_y == SAT_MAX || center_y == SAT_MIN)

    // input backpressure only follows a held output beat
    `TCU_ASSERT_IMPLY(a_stall_cause, clk, rst_n, point_stall, $past(center_valid && center_stall))

    // hold a stalled output beat
    `TCU_ASSERT_NEXT(a_out_hold, clk, rst_n, center_valid && center_stall, center_valid && $stable(center_x) && $stable(center_y) && $stable(degenerate) && $stable(saturated))

endmodule

bind triangle_circumcenter_unit tcu_checker u_tcu_checker (.*);

// ===== test/triangle_circumcenter_unit_tb.sv =====
// Testbench for the triangle circumcenter unit: random and directed point pairs, scoreboard check
`timescale 1ns / 100ps

module triangle_circumcenter_unit_tb;

    localparam int COORD_BITS     = 16;
    localparam int RANDOM_ITEMS   = 1334;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 3000;

    class center_book #(int CW = 16);
        typedef struct {
            logic signed [tcu_pkg::OUT_BITS-1:0] cx;
            logic signed [tcu_pkg::OUT_BITS-1:0] cy;
            logic                                deg;
            logic                                sat;
        } center_t;

        center_t pending_centers[$];
        int      mismatches;

        function new();
            mismatches = 0;
        endfunction

        function automatic logic signed [tcu_pkg::OUT_BITS-1:0] clip_quotient(
            input logic signed [127:0] num,
            input logic signed [127:0] den,
            inout logic                sat
        );
            logic signed [127:0] full;
            logic signed [127:0] top;
            logic signed [127:0] bottom;
            top    = 128'($signed(tcu_pkg::SAT_MAX));
            bottom = 128'($signed(tcu_pkg::SAT_MIN));
            full   = num / den;
            if (full > top)
            begin
                sat = 1'b1;
                return tcu_pkg::SAT_MAX;
            end
            if (full < bottom)
            begin
                sat = 1'b1;
                return tcu_pkg::SAT_MIN;
            end
            return full[tcu_pkg::OUT_BITS-1:0];
        endfunction

        function void note_points(input logic signed [CW-1:0] ax, ay, bx, by);
            logic signed [127:0] x1, y1, x2, y2, s1, s2, det;
            center_t c;
            x1 = 128'(ax);
            y1 = 128'(ay);
            x2 = 128'(bx);
            y2 = 128'(by);
            s1  = x1 * x1 + y1 * y1;
            s2  = x2 * x2 + y2 * y2;
            det = x1 * y2 - x2 * y1;
            c.sat = 1'b0;
            if (det == 0)
            begin
                c.cx  = '0;
                c.cy  = '0;
                c.deg = 1'b1;
            end
            else
            begin
                c.deg = 1'b0;
                c.cx  = clip_quotient(y2 * s1 - y1 * s2, 2 * det, c.sat);
                c.cy  = clip_quotient(x1 * s2 - x2 * s1, 2 * det, c.sat);
            end
            pending_centers.push_back(c);
        endfunction

        function void check_center(
            input logic signed [tcu_pkg::OUT_BITS-1:0] cx,
            input logic signed [tcu_pkg::OUT_BITS-1:0] cy,
            input logic                                deg,
            input logic                                sat
        );
            center_t c;
            if (pending_centers.size() == 0)
            begin
                $error("center beat with no point pair pending: x=%0d y=%0d", cx, cy);
                mismatches++;
                return;
            end
            c = pending_centers.pop_front();
            if (cx !== c.cx)
            begin
                $error("center_x: expected %0d, got %0d", c.cx, cx);
                mismatches++;
            end
            if (cy !== c.cy)
            begin
                $error("center_y: expected %0d, got %0d", c.cy, cy);
                mismatches++;
            end
            if (deg !== c.deg)
            begin
                $error("degenerate: expected %0b, got %0b", c.deg, deg);
                mismatches++;
            end
            if (sat !== c.sat)
            begin
                $error("saturated: expected %0b, got %0b", c.sat, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 point_valid;
    logic                                 point_stall;
    logic signed [COORD_BITS-1:0]         p1_x;
    logic signed [COORD_BITS-1:0]         p1_y;
    logic signed [COORD_BITS-1:0]         p2_x;
    logic signed [COORD_BITS-1:0]         p2_y;
    logic                                 center_valid;
    logic                                 center_stall;
    logic signed [tcu_pkg::OUT_BITS-1:0]  center_x;
    logic signed [tcu_pkg::OUT_BITS-1:0]  center_y;
    logic                                 degenerate;
    logic                                 saturated;

    center_book #(COORD_BITS) book;
    bit sender_calm = 1'b0;
    bit sink_calm   = 1'b0;
    bit hold_req    = 1'b0;
    int idle_cycles = 0;

    triangle_circumcenter_unit #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .point_valid(point_valid),
        .point_stall(point_stall),
        .p1_x(p1_x),
        .p1_y(p1_y),
        .p2_x(p2_x),
        .p2_y(p2_y),
        .center_valid(center_valid),
        .center_stall(center_stall),
        .center_x(center_x),
        .center_y(center_y),
        .degenerate(degenerate),
        .saturated(saturated)
    );

    always #6 clk = ~clk;

    task automatic offer_points(input int ax, input int ay, input int bx, input int by);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            point_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_valid = 1'b1;
        p1_x = COORD_BITS'(ax);
        p1_y = COORD_BITS'(ay);
        p2_x = COORD_BITS'(bx);
        p2_y = COORD_BITS'(by);
        do @(posedge clk); while (point_stall);
        book.note_points(p1_x, p1_y, p2_x, p2_y);
        @(negedge clk);
    endtask

    task automatic offer_random_pair();
        int kind, a, c, k, dx, dy, sx, sy;
        kind = $urandom_range(0, 9);
        case (kind) inside
            [3:4]:
                offer_points($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                             $urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048);
            5:
            begin
                // nearly collinear: det is a - c, tiny or zero
                a  = $urandom_range(0, 64000) - 32000;
                c  = a + $urandom_range(0, 6) - 3;
                sx = $urandom_range(0, 1) ? 1 : -1;
                offer_points(sx * a, sx * c, sx * (a + 1), sx * (c + 1));
            end
            6:
            begin
                // exactly collinear through the origin
                dx = $urandom_range(0, 8000) - 4000;
                dy = $urandom_range(0, 8000) - 4000;
                k  = $urandom_range(0, 16) - 8;
                offer_points(dx, dy, k * dx, k * dy);
            end
            7:
            begin
                a  = $urandom_range(0, 5);
                c  = $urandom_range(0, 5);
                sx = (a == 0) ? -32768 : (a == 1) ? 32767 : (a == 2) ? 0 : (a == 3) ? -1 : 1;
                sy = (c == 0) ? -32768 : (c == 1) ? 32767 : (c == 2) ? 0 : (c == 3) ? -1 : 1;
                if (a == 5)
                    sx = $urandom_range(0, 65535) - 32768;
                if (c == 5)
                    sy = $urandom_range(0, 65535) - 32768;
                offer_points(sx, $urandom_range(0, 65535) - 32768,
                             $urandom_range(0, 65535) - 32768, sy);
            end
            default:
                offer_points($urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && center_valid && !center_stall)
            book.check_center(center_x, center_y, degenerate, saturated);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (point_valid && !point_stall) || (center_valid && !center_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL triangle_circumcenter_unit");
            $finish;
        end
    end

    initial
    begin : center_sink
        int wait_n;
        center_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                center_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            wait_n = sink_calm ? 0 : $urandom_range(0, 5);
            if (wait_n > 0)
            begin
                center_stall = 1'b1;
                repeat (wait_n) @(negedge clk);
            end
            center_stall = 1'b0;
            do @(posedge clk); while (!center_valid);
            @(negedge clk);
        end
    end

    initial
    begin : point_source
        int n;
        book        = new();
        rst_n       = 1'b0;
        point_valid = 1'b0;
        p1_x        = '0;
        p1_y        = '0;
        p2_x        = '0;
        p2_y        = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        offer_points(0, 0, 0, 0);
        offer_points(256, 0, 0, 256);
        offer_points(768, 512, 768, 512);
        offer_points(256, 512, -512, -1024);
        offer_points(32767, 0, 0, 32767);
        offer_points(-32768, 0, 0, -32768);
        offer_points(-32768, -32768, 32767, 32767);
        offer_points(32767, -32768, -32768, 32767);
        offer_points(32000, 32001, 32001, 32002);
        offer_points(-32000, -32001, -32001, -32002);
        offer_points(32767, 32766, 32766, 32765);
        offer_points(1, 0, 0, 1);
        offer_points(3, 0, 0, 1);
        offer_points(-3, 0, 0, 1);
        offer_points(32767, 32767, -32768, 32767);
        offer_points(-32768, 32767, 32767, -32767);
        offer_points(2560, 1280, 768, -1792);
        offer_points(1, -32768, -32768, 1);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 200)
            begin
                sender_calm = 1'b1;
                sink_calm   = 1'b1;
            end
            if (n == 350)
            begin
                sink_calm = 1'b0;
                hold_req  = 1'b1;
            end
            if (n == 520)
                sender_calm = 1'b0;
            if (n == 700)
            begin
                // pause until every center has come back
                point_valid = 1'b0;
                while (book.pending_centers.size() != 0)
                    @(negedge clk);
            end
            offer_random_pair();
        end
        point_valid = 1'b0;

        while (book.pending_centers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (book.mismatches == 0)
            $display("PASS triangle_circumcenter_unit");
        else
            $display("FAIL triangle_circumcenter_unit");
        $finish;
    end

endmodule
